// File: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types and constants of the postfix expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int DIV_STEPS   = DATA_W;
	localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;
	localparam logic [7:0] SYM_ADD  = 8'h2b;
	localparam logic [7:0] SYM_SUB  = 8'h2d;
	localparam logic [7:0] SYM_MUL  = 8'h2a;
	localparam logic [7:0] SYM_DIV  = 8'h2f;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV
	} fsm_t;

endpackage

`default_nettype wire

// File: design/pfe_expr_if.sv
// ----------------------------------------------------------------------------
// pfe_expr_if
// input channel: one expression character or terminator per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_expr_if;

	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       end_of_expression;

	modport source (output valid, output symbol, output end_of_expression, input ready);
	modport sink (input valid, input symbol, input end_of_expression, output ready);

endinterface

`default_nettype wire

// File: design/pfe_result_if.sv
// ----------------------------------------------------------------------------
// pfe_result_if
// output channel: evaluated value and status per terminator
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_result_if;

	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [2:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);

endinterface

`default_nettype wire

// File: design/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pfe_pkg::DATA_W-1:0] dividend,
	input  wire logic [pfe_pkg::DATA_W-1:0] divisor,
	output logic                            done,
	output logic [pfe_pkg::DATA_W-1:0]      quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [pfe_pkg::DIV_STEP_W-1:0]  step_q;
	logic [pfe_pkg::DATA_W-1:0]      rem_q;
	logic [pfe_pkg::DATA_W-1:0]      quo_q;
	logic [pfe_pkg::DATA_W-1:0]      dvs_q;
	logic                            neg_q;
	logic [pfe_pkg::DATA_W:0]        shifted;
	logic [pfe_pkg::DATA_W:0]        trial;

	assign shifted  = {rem_q, quo_q[pfe_pkg::DATA_W-1]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = neg_q ? ('0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + pfe_pkg::DIV_STEP_W'(1);
				if (step_q == pfe_pkg::DIV_STEP_W'(pfe_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[pfe_pkg::DATA_W-1] ? ('0 - dividend) : dividend;
			dvs_q <= divisor[pfe_pkg::DATA_W-1] ? ('0 - divisor) : divisor;
			neg_q <= dividend[pfe_pkg::DATA_W-1] ^ divisor[pfe_pkg::DATA_W-1];
		end else if (busy_q) begin
			if (!trial[pfe_pkg::DATA_W]) begin
				rem_q <= trial[pfe_pkg::DATA_W-1:0];
				quo_q <= {quo_q[pfe_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[pfe_pkg::DATA_W-1:0];
				quo_q <= {quo_q[pfe_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire

// File: design/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// evaluates a postfix expression fed one character per transfer
// ----------------------------------------------------------------------------
// usage
//   expr channel: one ascii character per transfer; end_of_expression marks the
//   terminator, whose symbol is ignored. digits push, + - * / combine the two
//   top entries with 32-bit wrapping arithmetic, division truncating to zero.
//   result channel: one transfer per terminator with the top of stack and a
//   status (ok, overflow, underflow, divide by zero, invalid character); value
//   is zero on any error. the first error sticks until the terminator.
//   timing: + - * need one read of the stack memory, / needs that read plus
//   the 32-step serial divider; digits, errors and terminators need neither.
//   the result is registered in the cycle after the terminator transfer.
//   the top of stack lives in a register, the rest in a 128-entry memory.
//   a waiting result does not block characters; a terminator waits until the
//   result register is free. reset empties the stack and clears the error;
//   the memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pfe_expr_if.sink     expr,
	pfe_result_if.source result
);

	pfe_pkg::fsm_t                  state_q;
	pfe_pkg::fsm_t                  state_d;
	logic [pfe_pkg::CNT_W-1:0]      count_q;
	pfe_pkg::status_t               err_q;
	logic [pfe_pkg::DATA_W-1:0]     tos_q;
	pfe_pkg::op_t                   op_q;
	pfe_pkg::op_t                   op_dec;
	logic                           out_valid_q;
	logic [pfe_pkg::DATA_W-1:0]     out_value_q;
	pfe_pkg::status_t               out_status_q;

	logic [pfe_pkg::DATA_W-1:0]     mem [pfe_pkg::STACK_DEPTH];
	logic [pfe_pkg::DATA_W-1:0]     rd_data_q;
	logic                           wr_en;
	logic                           rd_en;
	logic [pfe_pkg::PTR_W-1:0]      wr_addr;
	logic [pfe_pkg::PTR_W-1:0]      rd_addr;

	logic                           accept;
	logic                           is_term;
	logic                           is_digit;
	logic                           is_op;
	logic                           stack_full;
	logic                           stack_short;
	logic                           do_push;
	logic                           do_op;
	logic                           div_start;
	logic                           div_done;
	logic [pfe_pkg::DATA_W-1:0]     div_quotient;
	logic [pfe_pkg::DATA_W-1:0]     alu_res;
	logic [pfe_pkg::CNT_W-1:0]      cnt_dec1;
	logic [pfe_pkg::CNT_W-1:0]      cnt_dec2;

	assign accept      = expr.valid && expr.ready;
	assign is_term     = expr.end_of_expression;
	assign is_digit    = (expr.symbol >= pfe_pkg::SYM_ZERO) && (expr.symbol <= pfe_pkg::SYM_NINE);
	assign stack_full  = (count_q == pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH));
	assign stack_short = (count_q < pfe_pkg::CNT_W'(2));
	assign cnt_dec1    = count_q - pfe_pkg::CNT_W'(1);
	assign cnt_dec2    = count_q - pfe_pkg::CNT_W'(2);
	assign wr_addr     = cnt_dec1[pfe_pkg::PTR_W-1:0];
	assign rd_addr     = cnt_dec2[pfe_pkg::PTR_W-1:0];

	always_comb begin
		is_op  = 1'b1;
		op_dec = pfe_pkg::OP_ADD;
		unique case (expr.symbol)
			pfe_pkg::SYM_ADD: op_dec = pfe_pkg::OP_ADD;
			pfe_pkg::SYM_SUB: op_dec = pfe_pkg::OP_SUB;
			pfe_pkg::SYM_MUL: op_dec = pfe_pkg::OP_MUL;
			pfe_pkg::SYM_DIV: op_dec = pfe_pkg::OP_DIV;
			default:          is_op  = 1'b0;
		endcase
	end

	// character that actually changes the stack
	assign do_push = accept && !is_term && (err_q == pfe_pkg::ST_OK) && is_digit && !stack_full;
	assign do_op   = accept && !is_term && (err_q == pfe_pkg::ST_OK) && !is_digit
		&& !stack_short && is_op && !((op_dec == pfe_pkg::OP_DIV) && (tos_q == '0));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfe_pkg::S_IDLE: if (do_op) state_d = pfe_pkg::S_READ;
			pfe_pkg::S_READ: state_d = (op_q == pfe_pkg::OP_DIV) ? pfe_pkg::S_DIV : pfe_pkg::S_IDLE;
			pfe_pkg::S_DIV:  if (div_done) state_d = pfe_pkg::S_IDLE;
			default:         state_d = pfe_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		expr.ready = (state_q == pfe_pkg::S_IDLE)
			&& (!expr.end_of_expression || !out_valid_q || result.ready);
		wr_en      = do_push && (count_q != '0);
		rd_en      = do_op;
		div_start  = (state_q == pfe_pkg::S_READ) && (op_q == pfe_pkg::OP_DIV);
	end

	always_comb begin
		unique case (op_q)
			pfe_pkg::OP_ADD: alu_res = rd_data_q + tos_q;
			pfe_pkg::OP_SUB: alu_res = rd_data_q - tos_q;
			pfe_pkg::OP_MUL: alu_res = rd_data_q * tos_q;
			pfe_pkg::OP_DIV: alu_res = rd_data_q;
			default:         alu_res = rd_data_q;
		endcase
	end

	pfe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data_q),
		.divisor  (tos_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= tos_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfe_pkg::S_IDLE;
			count_q     <= '0;
			err_q       <= pfe_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && is_term) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				err_q       <= pfe_pkg::ST_OK;
			end else if (accept && (err_q == pfe_pkg::ST_OK)) begin
				priority if (is_digit) begin
					if (stack_full) err_q <= pfe_pkg::ST_OVERFLOW;
					else count_q <= count_q + pfe_pkg::CNT_W'(1);
				end else if (stack_short) begin
					err_q <= pfe_pkg::ST_UNDERFLOW;
				end else if (!is_op) begin
					err_q <= pfe_pkg::ST_INVALID;
				end else if ((op_dec == pfe_pkg::OP_DIV) && (tos_q == '0)) begin
					err_q <= pfe_pkg::ST_DIVZERO;
				end else begin
					err_q <= pfe_pkg::ST_OK;
				end
			end else if ((state_q == pfe_pkg::S_READ) && (op_q != pfe_pkg::OP_DIV)) begin
				count_q <= cnt_dec1;
			end else if ((state_q == pfe_pkg::S_DIV) && div_done) begin
				count_q <= cnt_dec1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			tos_q <= {{(pfe_pkg::DATA_W - 4){1'b0}}, expr.symbol[3:0]};
		end else if ((state_q == pfe_pkg::S_READ) && (op_q != pfe_pkg::OP_DIV)) begin
			tos_q <= alu_res;
		end else if ((state_q == pfe_pkg::S_DIV) && div_done) begin
			tos_q <= div_quotient;
		end
		if (do_op) begin
			op_q <= op_dec;
		end
		if (accept && is_term) begin
			if (err_q != pfe_pkg::ST_OK) begin
				out_value_q  <= '0;
				out_status_q <= err_q;
			end else if (count_q == '0) begin
				out_value_q  <= '0;
				out_status_q <= pfe_pkg::ST_UNDERFLOW;
			end else begin
				out_value_q  <= tos_q;
				out_status_q <= pfe_pkg::ST_OK;
			end
		end
	end

	assign result.valid  = out_valid_q;
	assign result.value  = out_value_q;
	assign result.status = out_status_q;

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == pfe_pkg::S_DIV))
		else $error("divider finished outside the divide state");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH))
		else $error("stack count above depth");
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_term) |=> ((count_q == '0) && (err_q == pfe_pkg::ST_OK) && out_valid_q))
		else $error("terminator did not clear the stack or post a result");
	a_op_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfe_pkg::S_READ) |-> (count_q >= pfe_pkg::CNT_W'(2)))
		else $error("operator started with fewer than two entries");
`endif

endmodule

`default_nettype wire

// File: dv/postfix_expression_evaluator_tb.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// self-checking bench: expressions are queued as characters and terminators,
// a driver and a monitor on the two channels stall at random, and a
// behavioral stack machine predicts value and status of every terminator
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import pfe_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1350;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_START   = 400;
	localparam int unsigned HOLD_LEN     = 600;

	typedef struct packed {
		logic [7:0] symbol;
		logic       term;
	} expr_item_t;

	typedef struct {
		logic signed [31:0] value;
		status_t            status;
	} eval_result_t;

	logic clk;
	logic arst_n;

	pfe_expr_if   expr_ch ();
	pfe_result_if result_ch ();

	postfix_expression_evaluator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr_ch),
		.result (result_ch)
	);

	expr_item_t   symbol_queue[$];
	eval_result_t pending_results[$];

	logic [31:0] calc_stack [STACK_DEPTH];
	int unsigned calc_depth;
	status_t     calc_fault;

	int unsigned expr_transfers;
	int unsigned send_wait;
	bit          send_burst;
	expr_item_t  next_item;
	int unsigned take_wait;
	bit          take_burst;
	eval_result_t want;
	logic        result_hold;
	int unsigned hold_cycles;
	int unsigned fail_count;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// stack machine model, one accepted transfer at a time
	task automatic evaluate_symbol(input logic [7:0] sym, input logic term);
		logic [31:0]  lhs, rhs, res, lhs_mag, rhs_mag, quo;
		bit           done;
		eval_result_t r;
		if (term) begin
			r.value = '0;
			if (calc_fault != ST_OK) begin
				r.status = calc_fault;
			end else if (calc_depth == 0) begin
				r.status = ST_UNDERFLOW;
			end else begin
				r.value  = calc_stack[calc_depth - 1];
				r.status = ST_OK;
			end
			pending_results.push_back(r);
			calc_depth = 0;
			calc_fault = ST_OK;
		end else if (calc_fault == ST_OK) begin
			if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
				if (calc_depth >= STACK_DEPTH) begin
					calc_fault = ST_OVERFLOW;
				end else begin
					calc_stack[calc_depth] = 32'(sym - SYM_ZERO);
					calc_depth++;
				end
			end else if (calc_depth < 2) begin
				calc_fault = ST_UNDERFLOW;
			end else begin
				rhs  = calc_stack[calc_depth - 1];
				lhs  = calc_stack[calc_depth - 2];
				res  = '0;
				done = 1'b1;
				case (sym)
					SYM_ADD: res = lhs + rhs;
					SYM_SUB: res = lhs - rhs;
					SYM_MUL: res = lhs * rhs;
					SYM_DIV: begin
						if (rhs == 0) begin
							calc_fault = ST_DIVZERO;
							done       = 1'b0;
						end else begin
							lhs_mag = lhs[31] ? -lhs : lhs;
							rhs_mag = rhs[31] ? -rhs : rhs;
							quo     = lhs_mag / rhs_mag;
							res     = (lhs[31] != rhs[31]) ? -quo : quo;
						end
					end
					default: begin
						calc_fault = ST_INVALID;
						done       = 1'b0;
					end
				endcase
				if (done) begin
					calc_depth             = calc_depth - 2;
					calc_stack[calc_depth] = res;
					calc_depth++;
				end
			end
		end
	endtask

	task automatic queue_symbol(input logic [7:0] s);
		symbol_queue.push_back('{s, 1'b0});
	endtask

	task automatic queue_end();
		symbol_queue.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endtask

	function automatic logic [7:0] random_digit();
		return SYM_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_operator();
		op_t op;
		op = op_t'($urandom_range(0, 3));
		case (op)
			OP_ADD:  return SYM_ADD;
			OP_SUB:  return SYM_SUB;
			OP_MUL:  return SYM_MUL;
			default: return SYM_DIV;
		endcase
	endfunction

	// valid postfix with random content; corrupt replaces one random byte inside
	task automatic queue_wellformed(input int unsigned max_len, input int unsigned push_pct,
			input bit corrupt);
		int unsigned depth, len, bad_at;
		depth  = 0;
		len    = $urandom_range(1, max_len);
		bad_at = corrupt ? $urandom_range(0, len - 1) : len;
		for (int unsigned i = 0; i < len; i++) begin
			if (i == bad_at) begin
				queue_symbol(8'($urandom_range(0, 255)));
			end else if (depth < 2 || (depth < STACK_DEPTH - 2 &&
					$urandom_range(1, 100) <= push_pct)) begin
				queue_symbol(random_digit());
				depth++;
			end else begin
				queue_symbol(random_operator());
				depth--;
			end
		end
		while (depth > 1 && $urandom_range(0, 3) != 0) begin
			queue_symbol(random_operator());
			depth--;
		end
		queue_end();
	endtask

	task automatic queue_noise();
		int unsigned len;
		len = $urandom_range(1, 12);
		repeat (len) begin
			case ($urandom_range(0, 2))
				0:       queue_symbol(random_digit());
				1:       queue_symbol(random_operator());
				default: queue_symbol(8'($urandom_range(0, 255)));
			endcase
		end
		queue_end();
	endtask

	task automatic queue_overflow();
		repeat ($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2))
			queue_symbol(random_digit());
		if ($urandom_range(0, 1) == 0)
			queue_symbol(random_operator());
		queue_end();
	endtask

	// 2 * 8^10 wraps to the most negative value, then divide it by minus one
	task automatic queue_min_by_minus_one();
		queue_symbol(SYM_ZERO + 8'd2);
		repeat (10) queue_symbol(SYM_ZERO + 8'd8);
		repeat (10) queue_symbol(SYM_MUL);
		queue_symbol(SYM_ZERO);
		queue_symbol(SYM_ZERO + 8'd1);
		queue_symbol(SYM_SUB);
		queue_symbol(SYM_DIV);
		queue_end();
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expr_ch.valid             <= 1'b0;
			expr_ch.symbol            <= '0;
			expr_ch.end_of_expression <= 1'b0;
			expr_transfers            <= 0;
			send_wait  = 0;
			send_burst = 1'b0;
			calc_depth = 0;
			calc_fault = ST_OK;
		end else begin
			if (expr_ch.valid && expr_ch.ready) begin
				evaluate_symbol(expr_ch.symbol, expr_ch.end_of_expression);
				expr_transfers <= expr_transfers + 1;
			end
			if (!expr_ch.valid || expr_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					expr_ch.valid <= 1'b0;
				end else if (symbol_queue.size() > 0) begin
					next_item = symbol_queue.pop_front();
					expr_ch.valid             <= 1'b1;
					expr_ch.symbol            <= next_item.symbol;
					expr_ch.end_of_expression <= next_item.term;
					if ($urandom_range(0, 19) == 0)
						send_burst = !send_burst;
					send_wait = send_burst ? 0 : $urandom_range(0, 11);
				end else begin
					expr_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up into the input channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_hold <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_cycles < HOLD_LEN && expr_transfers >= HOLD_START) begin
			result_hold <= (hold_cycles < HOLD_LEN - 1);
			hold_cycles <= hold_cycles + 1;
		end else begin
			result_hold <= 1'b0;
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			take_wait  = 0;
			take_burst = 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transfer: value %0d status %0d",
							result_ch.value, result_ch.status);
				end else begin
					want = pending_results.pop_front();
					if (result_ch.value !== want.value || result_ch.status !== want.status) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: value exp %0d got %0d, status exp %0d got %0d",
								want.value, result_ch.value, want.status, result_ch.status);
					end
				end
				if ($urandom_range(0, 19) == 0)
					take_burst = !take_burst;
				take_wait = take_burst ? 0 : $urandom_range(0, 11);
			end
			if (result_hold) begin
				result_ch.ready <= 1'b0;
			end else if (take_wait > 0) begin
				take_wait--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned expr_idx, ovf_slot, min_slot, pick, directed_items;
		arst_n                    = 1'b0;
		expr_ch.valid             = 1'b0;
		expr_ch.symbol            = '0;
		expr_ch.end_of_expression = 1'b0;
		result_ch.ready           = 1'b0;
		fail_count                = 0;
		mismatch_count            = 0;
		cycle_count               = 0;

		// all four operators, digits 0 and 9, negative quotient truncated toward zero
		queue_symbol(SYM_ZERO);
		queue_symbol(SYM_NINE);
		queue_symbol(SYM_SUB);
		queue_symbol(SYM_ZERO + 8'd8);
		queue_symbol(SYM_MUL);
		queue_symbol(SYM_ZERO + 8'd7);
		queue_symbol(SYM_ADD);
		queue_symbol(SYM_ZERO + 8'd2);
		queue_symbol(SYM_DIV);
		queue_end();
		// zero divisor, then a valid add that the sticky error must swallow
		queue_symbol(SYM_ZERO + 8'd1);
		queue_symbol(SYM_ZERO);
		queue_symbol(SYM_DIV);
		queue_symbol(SYM_ADD);
		queue_end();
		// nul on a short stack reports underflow
		queue_symbol(SYM_ZERO + 8'd4);
		queue_symbol(8'h00);
		queue_end();
		// unknown character with two operands
		queue_symbol(SYM_ZERO + 8'd3);
		queue_symbol(SYM_ZERO + 8'd2);
		queue_symbol(8'hff);
		queue_end();
		// terminator on empty stack
		queue_end();
		// extra operands left under the top
		queue_symbol(SYM_ZERO + 8'd1);
		queue_symbol(SYM_ZERO + 8'd2);
		queue_symbol(SYM_NINE);
		queue_end();
		directed_items = symbol_queue.size();

		expr_idx = 0;
		ovf_slot = $urandom_range(0, 15);
		min_slot = ovf_slot + $urandom_range(1, 15);
		while (symbol_queue.size() < directed_items + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (expr_idx == ovf_slot || pick < 2)
				queue_overflow();
			else if (expr_idx == min_slot || pick < 6)
				queue_min_by_minus_one();
			else if (pick < 62)
				queue_wellformed(16, 35, 1'b0);
			else if (pick < 66)
				queue_wellformed(100, 75, 1'b0);
			else if (pick < 80)
				queue_wellformed(16, 35, 1'b1);
			else
				queue_noise();
			expr_idx++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (symbol_queue.size() > 0 || expr_ch.valid)
			@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: postfix_expression_evaluator.f
design/pfe_pkg.sv
design/pfe_expr_if.sv
design/pfe_result_if.sv
design/pfe_div.sv
design/postfix_expression_evaluator.sv
dv/postfix_expression_evaluator_tb.sv
